@@ rtl/gope_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the glyph outline point encoder.
// No dependencies; the front end, queue, back end and top level import this package.
package gope_pkg;

   // glyf flag bits, and NO_RUN marking that no flag run is open
   localparam logic [7:0] NO_RUN    = 8'h80;
   localparam logic [7:0] FL_ON     = 8'h01;
   localparam logic [7:0] FL_XSHORT = 8'h02;
   localparam logic [7:0] FL_YSHORT = 8'h04;
   localparam logic [7:0] FL_REPEAT = 8'h08;
   localparam logic [7:0] FL_SAMEX  = 8'h10;
   localparam logic [7:0] FL_SAMEY  = 8'h20;

   // saturation limits for the rounded coordinate
   localparam logic signed [22:0] COORD_MAX = 23'sd32767;
   localparam logic signed [22:0] COORD_MIN = -23'sd32768;

   // short delta limits
   localparam logic signed [16:0] SHORT_MAX = 17'sd256;
   localparam logic signed [16:0] SHORT_MIN = -17'sd256;

   localparam logic [1:0] CNT_NONE  = 2'd0;
   localparam logic [1:0] CNT_SHORT = 2'd1;
   localparam logic [1:0] CNT_LONG  = 2'd2;

   typedef logic signed [15:0] coord_type;

   typedef struct packed {
      logic [15:0] bytes;
      logic [1:0]  count;
      logic [7:0]  flags;
   } delta_type;

   // one classified point as it waits between front and back
   typedef struct packed {
      logic [15:0] x_bytes;
      logic [1:0]  x_count;
      logic [15:0] y_bytes;
      logic [1:0]  y_count;
      logic        closed_valid;
      logic [7:0]  closed_flag;
      logic [7:0]  closed_rep;
      logic        last;
      logic [7:0]  tail_flag;
      logic [7:0]  tail_rep;
      coord_type   box_xmin;
      coord_type   box_ymin;
      coord_type   box_xmax;
      coord_type   box_ymax;
   } record_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

@@ rtl/gope_req_if.sv @@
`timescale 1ns / 1ps
// Point channel: valid/ready handshake with the point word.
// No dependencies.
interface gope_req_if;
   logic               valid;
   logic               ready;
   logic signed [21:0] point_x;
   logic signed [21:0] point_y;
   logic               on_path;
   logic               first_point;
   logic               last_point;

   modport source (output valid, point_x, point_y, on_path, first_point, last_point,
                   input ready);
   modport sink   (input valid, point_x, point_y, on_path, first_point, last_point,
                   output ready);
endinterface

@@ rtl/gope_rsp_if.sv @@
`timescale 1ns / 1ps
// Result channel: valid/ready handshake with the encoded word.
// No dependencies.
interface gope_rsp_if;
   logic               valid;
   logic               ready;
   logic [15:0]        x_bytes;
   logic [1:0]         x_count;
   logic [15:0]        y_bytes;
   logic [1:0]         y_count;
   logic               flag_valid;
   logic [7:0]         flag_byte;
   logic [7:0]         repeat_count;
   logic signed [15:0] box_xmin;
   logic signed [15:0] box_ymin;
   logic signed [15:0] box_xmax;
   logic signed [15:0] box_ymax;
   logic               glyph_done;

   modport source (output valid, x_bytes, x_count, y_bytes, y_count, flag_valid,
                   flag_byte, repeat_count, box_xmin, box_ymin, box_xmax, box_ymax,
                   glyph_done, input ready);
   modport sink   (input valid, x_bytes, x_count, y_bytes, y_count, flag_valid,
                   flag_byte, repeat_count, box_xmin, box_ymin, box_xmax, box_ymax,
                   glyph_done, output ready);
endinterface

@@ rtl/gope_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts points, rounds, encodes deltas, merges flag runs, tracks box.
// Depends on gope_pkg and gope_req_if.
module gope_front import gope_pkg::*; #(
   parameter int FRACTION_BITS = 6,
   parameter int MAX_REPEATS   = 255
) (
   input  logic         clock,
   input  logic         reset,
   gope_req_if.sink     req_bus,
   input  q_status_type q_status,
   output logic         push,
   output record_type   rec
);

   localparam logic signed [22:0] HALF      = 23'((1 << FRACTION_BITS) >> 1);
   localparam logic [7:0]         REP_LIMIT = 8'(MAX_REPEATS);

   function automatic coord_type round_sat(input logic signed [21:0] raw);
      logic signed [22:0] sum;
      logic signed [22:0] r;
      sum = 23'(raw) + HALF;
      r   = sum >>> FRACTION_BITS;
      if (r > COORD_MAX) begin
         round_sat = 16'(COORD_MAX);
      end else if (r < COORD_MIN) begin
         round_sat = 16'(COORD_MIN);
      end else begin
         round_sat = 16'(r);
      end
   endfunction

   function automatic delta_type enc_delta(input logic signed [16:0] d,
                                           input logic [7:0] short_bit,
                                           input logic [7:0] same_bit);
      delta_type e;
      if (d == 17'sd0) begin
         e.bytes = 16'd0;
         e.count = CNT_NONE;
         e.flags = same_bit;
      end else if (d < SHORT_MAX && d > SHORT_MIN) begin
         e.count = CNT_SHORT;
         if (d < 17'sd0) begin
            e.bytes = 16'(-d);
            e.flags = short_bit;
         end else begin
            e.bytes = 16'(d);
            e.flags = short_bit | same_bit;
         end
      end else begin
         e.bytes = d[15:0];
         e.count = CNT_LONG;
         e.flags = 8'd0;
      end
      enc_delta = e;
   endfunction

   coord_type prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   coord_type low_x_ff, low_x_in, low_y_ff, low_y_in;
   coord_type high_x_ff, high_x_in, high_y_ff, high_y_in;
   logic [7:0] run_flag_ff, run_flag_in, run_rep_ff, run_rep_in;

   coord_type xc, yc, px, py;
   coord_type lx, ly, hx, hy;
   logic signed [16:0] dx, dy;
   delta_type ex, ey;
   logic [7:0] f, rflag, rrep, new_flag, new_rep;
   logic first, merge;

   assign req_bus.ready = !q_status.full;
   assign push          = req_bus.valid && !q_status.full;

   always_comb begin
      first = req_bus.first_point;
      xc    = round_sat(req_bus.point_x);
      yc    = round_sat(req_bus.point_y);
      px    = first ? 16'sd0 : prev_x_ff;
      py    = first ? 16'sd0 : prev_y_ff;
      dx    = 17'(xc) - 17'(px);
      dy    = 17'(yc) - 17'(py);
      ex    = enc_delta(dx, FL_XSHORT, FL_SAMEX);
      ey    = enc_delta(dy, FL_YSHORT, FL_SAMEY);
      f     = (req_bus.on_path ? FL_ON : 8'd0) | ex.flags | ey.flags;

      // a first point drops any open run
      rflag = first ? NO_RUN : run_flag_ff;
      rrep  = first ? 8'd0 : run_rep_ff;
      merge = (rflag != NO_RUN) && (f == rflag) && (rrep < REP_LIMIT);
      if (merge) begin
         new_flag = rflag;
         new_rep  = rrep + 8'd1;
      end else begin
         new_flag = f;
         new_rep  = 8'd0;
      end

      lx = first ? xc : low_x_ff;
      ly = first ? yc : low_y_ff;
      hx = first ? xc : high_x_ff;
      hy = first ? yc : high_y_ff;
      low_x_in  = (xc < lx) ? xc : lx;
      low_y_in  = (yc < ly) ? yc : ly;
      high_x_in = (xc > hx) ? xc : hx;
      high_y_in = (yc > hy) ? yc : hy;
      prev_x_in = xc;
      prev_y_in = yc;

      if (req_bus.last_point) begin
         run_flag_in = NO_RUN;
         run_rep_in  = 8'd0;
      end else begin
         run_flag_in = new_flag;
         run_rep_in  = new_rep;
      end

      rec.x_bytes      = ex.bytes;
      rec.x_count      = ex.count;
      rec.y_bytes      = ey.bytes;
      rec.y_count      = ey.count;
      rec.closed_valid = !merge && (rflag != NO_RUN);
      rec.closed_flag  = rflag | ((rrep != 8'd0) ? FL_REPEAT : 8'd0);
      rec.closed_rep   = rrep;
      rec.last         = req_bus.last_point;
      rec.tail_flag    = new_flag | ((new_rep != 8'd0) ? FL_REPEAT : 8'd0);
      rec.tail_rep     = new_rep;
      rec.box_xmin     = low_x_in;
      rec.box_ymin     = low_y_in;
      rec.box_xmax     = high_x_in;
      rec.box_ymax     = high_y_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff   <= '0;
         prev_y_ff   <= '0;
         low_x_ff    <= '0;
         low_y_ff    <= '0;
         high_x_ff   <= '0;
         high_y_ff   <= '0;
         run_flag_ff <= NO_RUN;
         run_rep_ff  <= '0;
      end else if (push) begin
         prev_x_ff   <= prev_x_in;
         prev_y_ff   <= prev_y_in;
         low_x_ff    <= low_x_in;
         low_y_ff    <= low_y_in;
         high_x_ff   <= high_x_in;
         high_y_ff   <= high_y_in;
         run_flag_ff <= run_flag_in;
         run_rep_ff  <= run_rep_in;
      end
   end

`ifndef ASSERT_OFF
   a_rep_limit: assert property (@(posedge clock) disable iff (reset)
      run_rep_ff <= REP_LIMIT)
      else $error("run repeat count above limit");
`endif

endmodule

@@ rtl/gope_queue.sv @@
`timescale 1ns / 1ps
// Short record queue between the front end and the back end.
// Depends on gope_pkg.
module gope_queue import gope_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  record_type   push_rec,
   input  logic         pop,
   output record_type   head_rec,
   output q_status_type q_status
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
   localparam logic [AW:0]   FULL_CNT  = (AW + 1)'(DEPTH);

   record_type slot_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [AW:0]   count_ff, count_in;

   assign head_rec       = slot_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == FULL_CNT);
   assign q_status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push ? ((wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? ((rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff + (AW + 1)'(push) - (AW + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_rec;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !push)
      else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("pop from empty queue");
`endif

endmodule

@@ rtl/gope_back.sv @@
`timescale 1ns / 1ps
// Back end: turns queued records into one or two result words in an output register.
// Depends on gope_pkg and gope_rsp_if.
module gope_back import gope_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  record_type   head_rec,
   input  q_status_type q_status,
   output logic         pop,
   gope_rsp_if.source   rsp_bus
);

   logic        valid_ff, phase_ff, phase_in;
   logic [15:0] x_bytes_ff, x_bytes_in, y_bytes_ff, y_bytes_in;
   logic [1:0]  x_count_ff, x_count_in, y_count_ff, y_count_in;
   logic        flag_valid_ff, flag_valid_in, done_ff, done_in;
   logic [7:0]  flag_ff, flag_in, rep_ff, rep_in;
   coord_type   xmin_ff, xmin_in, ymin_ff, ymin_in, xmax_ff, xmax_in, ymax_ff, ymax_in;
   logic        out_free, load, two, boxed;

   always_comb begin
      out_free = !valid_ff || rsp_bus.ready;
      load     = out_free && !q_status.empty;
      two      = head_rec.last && head_rec.closed_valid;
      pop      = load && (!two || phase_ff);
      phase_in = load ? (two && !phase_ff) : phase_ff;

      if (phase_ff) begin
         // second word: flushed run and box only
         x_bytes_in    = 16'd0;
         x_count_in    = CNT_NONE;
         y_bytes_in    = 16'd0;
         y_count_in    = CNT_NONE;
         flag_valid_in = 1'b1;
         flag_in       = head_rec.tail_flag;
         rep_in        = head_rec.tail_rep;
         boxed         = 1'b1;
      end else begin
         x_bytes_in = head_rec.x_bytes;
         x_count_in = head_rec.x_count;
         y_bytes_in = head_rec.y_bytes;
         y_count_in = head_rec.y_count;
         boxed      = head_rec.last && !head_rec.closed_valid;
         if (head_rec.closed_valid) begin
            flag_valid_in = 1'b1;
            flag_in       = head_rec.closed_flag;
            rep_in        = head_rec.closed_rep;
         end else if (head_rec.last) begin
            flag_valid_in = 1'b1;
            flag_in       = head_rec.tail_flag;
            rep_in        = head_rec.tail_rep;
         end else begin
            flag_valid_in = 1'b0;
            flag_in       = 8'd0;
            rep_in        = 8'd0;
         end
      end
      done_in = boxed;
      xmin_in = boxed ? head_rec.box_xmin : 16'sd0;
      ymin_in = boxed ? head_rec.box_ymin : 16'sd0;
      xmax_in = boxed ? head_rec.box_xmax : 16'sd0;
      ymax_in = boxed ? head_rec.box_ymax : 16'sd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         if (out_free) begin
            valid_ff <= load;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         x_bytes_ff    <= x_bytes_in;
         x_count_ff    <= x_count_in;
         y_bytes_ff    <= y_bytes_in;
         y_count_ff    <= y_count_in;
         flag_valid_ff <= flag_valid_in;
         flag_ff       <= flag_in;
         rep_ff        <= rep_in;
         xmin_ff       <= xmin_in;
         ymin_ff       <= ymin_in;
         xmax_ff       <= xmax_in;
         ymax_ff       <= ymax_in;
         done_ff       <= done_in;
      end
   end

   assign rsp_bus.valid        = valid_ff;
   assign rsp_bus.x_bytes      = x_bytes_ff;
   assign rsp_bus.x_count      = x_count_ff;
   assign rsp_bus.y_bytes      = y_bytes_ff;
   assign rsp_bus.y_count      = y_count_ff;
   assign rsp_bus.flag_valid   = flag_valid_ff;
   assign rsp_bus.flag_byte    = flag_ff;
   assign rsp_bus.repeat_count = rep_ff;
   assign rsp_bus.box_xmin     = xmin_ff;
   assign rsp_bus.box_ymin     = ymin_ff;
   assign rsp_bus.box_xmax     = xmax_ff;
   assign rsp_bus.box_ymax     = ymax_ff;
   assign rsp_bus.glyph_done   = done_ff;

`ifndef ASSERT_OFF
   a_phase_holds_record: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (!q_status.empty && valid_ff))
      else $error("second word pending without its record");
   a_done_has_flag: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && done_ff) |-> flag_valid_ff)
      else $error("glyph end word without flushed flag entry");
`endif

endmodule

@@ rtl/glyph_outline_point_encoder.sv @@
`timescale 1ns / 1ps
// Glyph outline point encoder: glyf coordinate deltas, flag runs and bounding box.
// Depends on gope_pkg, gope_req_if, gope_rsp_if, gope_front, gope_queue, gope_back.
//
// Usage:
//   req_bus carries one outline point per word (16.6 fixed point x and y, on_path,
//   first_point, last_point); a word moves when valid and ready are both high.
//   rsp_bus carries result words: delta bytes for x and y, a closed flag run entry
//   when one completes, and on the glyph's final word the bounding box with
//   glyph_done set.
//   The accepting edge writes a point's record into the queue; the back end then
//   loads it from the queue head into the output register once that register is
//   free and the records ahead of it have left.
//   Throughput: one point per cycle while the queue is not full. A last point that
//   closes a run and flushes the open one yields two words and holds the back end
//   for both; the queue absorbs this while the front end keeps taking points.
//   The front end's rounding, delta and run-merge logic is combinational; the
//   queue depth (QUEUE_DEPTH) sets how long the front end runs on during a stall.
//   Stall: while rsp_bus.ready is low the output word holds, the queue fills, and
//   req_bus.ready drops once the queue is full; nothing is lost.
//   Reset (synchronous, active high): empty queue and output register, previous
//   point and box at zero, no open flag run.
module glyph_outline_point_encoder import gope_pkg::*; #(
   parameter int FRACTION_BITS = 6,
   parameter int MAX_REPEATS   = 255,
   parameter int QUEUE_DEPTH   = 4
) (
   input  logic       clock,
   input  logic       reset,
   gope_req_if.sink   req_bus,
   gope_rsp_if.source rsp_bus
);

   // front to queue
   logic         push;
   record_type   push_rec;
   // queue to back
   record_type   head_rec;
   q_status_type q_status;
   logic         pop;

   // classify each point and update glyph state on acceptance
   gope_front #(
      .FRACTION_BITS (FRACTION_BITS),
      .MAX_REPEATS   (MAX_REPEATS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .q_status (q_status),
      .push     (push),
      .rec      (push_rec)
   );

   // hold classified points so either side may stall on its own
   gope_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .head_rec (head_rec),
      .q_status (q_status)
   );

   // emit one or two result words per record
   gope_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_rec (head_rec),
      .q_status (q_status),
      .pop      (pop),
      .rsp_bus  (rsp_bus)
   );

endmodule
